### design/ac3fs_pkg.sv
`default_nettype none
package ac3fs_pkg;

  localparam int STORE_BYTES  = 4096;
  localparam int AW           = $clog2(STORE_BYTES);
  localparam int HEADER_BYTES = 7;
  localparam int BURST_WORDS  = 3072;
  localparam int NUM_SIZES    = 38;

  localparam logic [7:0]  SYNC_HI    = 8'h0B;
  localparam logic [7:0]  SYNC_LO    = 8'h77;
  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [15:0] PREAMBLE_A = 16'hF872;
  localparam logic [15:0] PREAMBLE_B = 16'h4E1F;
  localparam logic [7:0]  TYPE_AC3   = 8'h01;
  localparam logic [7:0]  BSMOD_MASK = 8'h07;
  localparam logic [7:0]  FRMSIZE_MASK = 8'h3F;
  localparam logic [1:0]  FS_RESERVED = 2'd3;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic [11:0] idx;
  } req_t;

  // One byte of CRC-16 0x8005, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Ring position advance; both operands are below STORE_BYTES.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p, input logic [AW-1:0] n);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= (AW+1)'(STORE_BYTES)) begin
      s = s - (AW+1)'(STORE_BYTES);
    end
    return s[AW-1:0];
  endfunction

  // Frame length in 16-bit words for frmsizecod and fscod.
  function automatic logic [10:0] frame_size(input logic [5:0] fr, input logic [1:0] fs);
    logic [10:0] w48, w44, w32;
    w48 = '0; w44 = '0; w32 = '0;
    unique case (fr[5:1])
      5'd0:  begin w48 = 11'd64;   w44 = 11'd69;   w32 = 11'd96;   end
      5'd1:  begin w48 = 11'd80;   w44 = 11'd87;   w32 = 11'd120;  end
      5'd2:  begin w48 = 11'd96;   w44 = 11'd104;  w32 = 11'd144;  end
      5'd3:  begin w48 = 11'd112;  w44 = 11'd121;  w32 = 11'd168;  end
      5'd4:  begin w48 = 11'd128;  w44 = 11'd139;  w32 = 11'd192;  end
      5'd5:  begin w48 = 11'd160;  w44 = 11'd174;  w32 = 11'd240;  end
      5'd6:  begin w48 = 11'd192;  w44 = 11'd208;  w32 = 11'd288;  end
      5'd7:  begin w48 = 11'd224;  w44 = 11'd243;  w32 = 11'd336;  end
      5'd8:  begin w48 = 11'd256;  w44 = 11'd278;  w32 = 11'd384;  end
      5'd9:  begin w48 = 11'd320;  w44 = 11'd348;  w32 = 11'd480;  end
      5'd10: begin w48 = 11'd384;  w44 = 11'd417;  w32 = 11'd576;  end
      5'd11: begin w48 = 11'd448;  w44 = 11'd487;  w32 = 11'd672;  end
      5'd12: begin w48 = 11'd512;  w44 = 11'd557;  w32 = 11'd768;  end
      5'd13: begin w48 = 11'd640;  w44 = 11'd696;  w32 = 11'd960;  end
      5'd14: begin w48 = 11'd768;  w44 = 11'd835;  w32 = 11'd1152; end
      5'd15: begin w48 = 11'd896;  w44 = 11'd975;  w32 = 11'd1344; end
      5'd16: begin w48 = 11'd1024; w44 = 11'd1114; w32 = 11'd1536; end
      5'd17: begin w48 = 11'd1152; w44 = 11'd1253; w32 = 11'd1728; end
      5'd18: begin w48 = 11'd1280; w44 = 11'd1393; w32 = 11'd1920; end
      default: begin w48 = '0; w44 = '0; w32 = '0; end
    endcase
    w44 = w44 + {10'd0, fr[0]};
    unique case (fs)
      2'd0:    return w48;
      2'd1:    return w44;
      default: return w32;
    endcase
  endfunction

endpackage
`default_nettype wire

### design/ac3fs_ram.sv
`default_nettype none
module ac3fs_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### design/ac3fs_front.sv
`default_nettype none
module ac3fs_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic [11:0]        word_index_i,
  output      logic               q_valid_o,
  output      ac3fs_pkg::req_t    q_req_o,
  input  wire logic               q_pop_i
);
  import ac3fs_pkg::*;

  req_t       slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  req_t       incoming;

  // Classify the incoming transaction
  always_comb begin
    incoming.op   = req_type_i ? OP_READ : OP_PUSH;
    incoming.data = data_byte_i;
    incoming.idx  = word_index_i;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = slot_q[0];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shift queue: head in slot 0
  always_ff @(posedge clk_i) begin
    if (q_pop_i) begin
      slot_q[0] <= (push && cnt_q == 2'd1) ? incoming : slot_q[1];
      if (push && cnt_q == 2'd2) begin
        slot_q[1] <= incoming;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        slot_q[0] <= incoming;
      end else begin
        slot_q[1] <= incoming;
      end
    end
  end
endmodule
`default_nettype wire

### design/ac3fs_back.sv
`default_nettype none
module ac3fs_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_valid_i,
  input  wire ac3fs_pkg::req_t         q_req_i,
  output      logic                    q_pop_o,
  output      logic                    mem_we_o,
  output      logic [ac3fs_pkg::AW-1:0] mem_waddr_o,
  output      logic [7:0]              mem_wdata_o,
  output      logic [ac3fs_pkg::AW-1:0] mem_raddr_o,
  input  wire logic [7:0]              mem_rdata_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic                    frame_ready_o,
  output      logic [15:0]             read_word_o,
  output      logic [1:0]              rate_code_o,
  output      logic [10:0]             frame_words_o,
  output      logic [2:0]              stream_mode_o,
  output      logic [15:0]             skipped_bytes_o
);
  import ac3fs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PCHK  = 3'd1;
  localparam logic [2:0] S_PBYTE = 3'd2;
  localparam logic [2:0] S_RHI   = 3'd3;
  localparam logic [2:0] S_RLO   = 3'd4;
  localparam logic [2:0] S_RFIN  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [1:0] PH_SEEK1 = 2'd0;
  localparam logic [1:0] PH_SEEK2 = 2'd1;
  localparam logic [1:0] PH_HEAD  = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  logic [2:0]    state_q;
  logic [1:0]    phase_q;
  logic [AW-1:0] wcount_q, rpos_q, rend_q, start_q;
  logic [15:0]   crc_q, skip_q;
  logic [11:0]   cnt_q, crc1_len_q, tot_q;
  logic [10:0]   cand_words_q, size_q;
  logic [1:0]    rate_q;
  logic [2:0]    mode_q, bsmod_q;
  logic [7:0]    code_q, hi_q;
  logic          crc1_good_q;
  logic [12:0]   off_q;
  logic          res_ready_q;
  logic [15:0]   res_word_q, res_skip_q;

  logic [7:0]    b;
  logic [15:0]   crc_n;
  logic [11:0]   cnt_n;
  logic [12:0]   off_n;
  logic [11:0]   len_bytes;
  logic [10:0]   hdr_words;
  logic          out_free;
  logic          hdr_bad, body_end, body_good;
  logic          parse_restart, parse_accept;

  function automatic logic [15:0] sat_add(input logic [15:0] s, input logic [1:0] n);
    logic [16:0] t;
    t = {1'b0, s} + {15'd0, n};
    return t[16] ? 16'hFFFF : t[15:0];
  endfunction

  assign b         = mem_rdata_i;
  assign crc_n     = crc_byte(crc_q, b);
  assign cnt_n     = cnt_q + 12'd1;
  assign off_n     = {q_req_i.idx, 1'b0} - 13'd8;
  assign len_bytes = {size_q, 1'b0};
  assign hdr_words = frame_size(code_q[5:0] & FRMSIZE_MASK[5:0], code_q[7:6]);
  assign out_free  = !out_valid_o || !out_stall_i;

  // Decide the outcome of the byte being parsed
  always_comb begin
    hdr_bad       = (code_q[7:6] == FS_RESERVED) ||
                    ((code_q[5:0] & FRMSIZE_MASK[5:0]) >= 6'(NUM_SIZES));
    body_end      = (phase_q == PH_BODY) && (cnt_n == tot_q);
    body_good     = crc1_good_q && (crc_n == 16'd0);
    parse_restart = ((phase_q == PH_HEAD) && (cnt_n == 12'(HEADER_BYTES)) && hdr_bad) ||
                    (body_end && !body_good);
    parse_accept  = body_end && body_good;
  end

  // Store write and read addressing
  always_comb begin
    q_pop_o     = (state_q == S_IDLE) && q_valid_i;
    mem_we_o    = q_pop_o && (q_req_i.op == OP_PUSH);
    mem_waddr_o = wcount_q;
    mem_wdata_o = q_req_i.data;
    unique case (state_q)
      S_RHI:   mem_raddr_o = ring_add(rend_q, off_q[AW-1:0]);
      S_RLO:   mem_raddr_o = ring_add(rend_q, ring_add(off_q[AW-1:0], AW'(1)));
      default: mem_raddr_o = rpos_q;
    endcase
  end

  // Sequencer: push, parse loop, burst read, result hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      phase_q         <= PH_SEEK1;
      wcount_q        <= '0;
      rpos_q          <= '0;
      rend_q          <= '0;
      start_q         <= '0;
      crc_q           <= '0;
      skip_q          <= '0;
      cnt_q           <= '0;
      crc1_len_q      <= '0;
      tot_q           <= '0;
      cand_words_q    <= '0;
      size_q          <= '0;
      rate_q          <= '0;
      mode_q          <= '0;
      bsmod_q         <= '0;
      code_q          <= '0;
      hi_q            <= '0;
      crc1_good_q     <= 1'b0;
      off_q           <= '0;
      res_ready_q     <= 1'b0;
      res_word_q      <= '0;
      res_skip_q      <= '0;
      out_valid_o     <= 1'b0;
      frame_ready_o   <= 1'b0;
      read_word_o     <= '0;
      rate_code_o     <= '0;
      frame_words_o   <= '0;
      stream_mode_o   <= '0;
      skipped_bytes_o <= '0;
    end else begin
      if (out_valid_o && !out_stall_i && state_q != S_EMIT) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            res_ready_q <= 1'b0;
            if (q_req_i.op == OP_PUSH) begin
              res_word_q <= '0;
              wcount_q   <= ring_add(wcount_q, AW'(1));
              state_q    <= S_PCHK;
            end else begin
              res_skip_q <= skip_q;
              off_q      <= off_n;
              state_q    <= S_EMIT;
              if (q_req_i.idx >= 12'(BURST_WORDS)) begin
                res_word_q <= '0;
              end else if (q_req_i.idx == 12'd0) begin
                res_word_q <= PREAMBLE_A;
              end else if (q_req_i.idx == 12'd1) begin
                res_word_q <= PREAMBLE_B;
              end else if (q_req_i.idx == 12'd2) begin
                res_word_q <= {5'd0, mode_q, TYPE_AC3};
              end else if (q_req_i.idx == 12'd3) begin
                res_word_q <= {1'b0, size_q, 4'd0};
              end else begin
                state_q <= S_RHI;
              end
            end
          end
        end
        S_PCHK: begin
          if (rpos_q == wcount_q) begin
            res_skip_q <= skip_q;
            state_q    <= S_EMIT;
          end else begin
            state_q <= S_PBYTE;
          end
        end
        S_PBYTE: begin
          state_q <= parse_accept ? S_EMIT : S_PCHK;
          rpos_q  <= parse_restart ? ring_add(start_q, AW'(2)) : ring_add(rpos_q, AW'(1));
          unique case (phase_q)
            PH_SEEK1: begin
              if (b == SYNC_HI) begin
                phase_q <= PH_SEEK2;
                start_q <= rpos_q;
              end else begin
                skip_q <= sat_add(skip_q, 2'd1);
              end
            end
            PH_SEEK2: begin
              if (b == SYNC_LO) begin
                phase_q <= PH_HEAD;
                cnt_q   <= 12'd2;
                crc_q   <= '0;
              end else begin
                phase_q <= PH_SEEK1;
                skip_q  <= sat_add(skip_q, 2'd2);
              end
            end
            PH_HEAD: begin
              crc_q <= crc_n;
              cnt_q <= cnt_n;
              if (cnt_n == 12'd5) begin
                code_q <= b;
              end
              if (cnt_n == 12'd6) begin
                bsmod_q <= b[2:0] & BSMOD_MASK[2:0];
              end
              if (cnt_n == 12'(HEADER_BYTES)) begin
                if (hdr_bad) begin
                  phase_q <= PH_SEEK1;
                  skip_q  <= sat_add(skip_q, 2'd2);
                end else begin
                  rate_q       <= code_q[7:6];
                  cand_words_q <= hdr_words;
                  crc1_len_q   <= {({1'b0, hdr_words[10:1]} + {3'd0, hdr_words[10:3]}), 1'b0};
                  tot_q        <= {hdr_words, 1'b0};
                  crc1_good_q  <= 1'b0;
                  phase_q      <= PH_BODY;
                end
              end
            end
            default: begin
              crc_q <= crc_n;
              cnt_q <= cnt_n;
              if (cnt_n == crc1_len_q) begin
                crc1_good_q <= (crc_n == 16'd0);
              end
              if (body_end) begin
                phase_q <= PH_SEEK1;
                if (!body_good) begin
                  skip_q <= sat_add(skip_q, 2'd2);
                end else begin
                  mode_q      <= bsmod_q;
                  size_q      <= cand_words_q;
                  rend_q      <= start_q;
                  res_skip_q  <= skip_q;
                  skip_q      <= '0;
                  res_ready_q <= 1'b1;
                end
              end
            end
          endcase
        end
        S_RHI: begin
          state_q <= S_RLO;
        end
        S_RLO: begin
          hi_q    <= (off_q < {1'b0, len_bytes}) ? b : 8'd0;
          state_q <= S_RFIN;
        end
        S_RFIN: begin
          res_word_q <= {hi_q, ((off_q + 13'd1) < {1'b0, len_bytes}) ? b : 8'd0};
          state_q    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_o     <= 1'b1;
            frame_ready_o   <= res_ready_q;
            read_word_o     <= res_word_q;
            rate_code_o     <= rate_q;
            frame_words_o   <= size_q;
            stream_mode_o   <= mode_q;
            skipped_bytes_o <= res_skip_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/ac3_frame_sync_iec_burst_packer.sv
`default_nettype none
// AC-3 sync and IEC 61937 burst packer. A push transaction stores one stream
// byte in a 4096-byte ring and then parses all unparsed bytes, each through
// the S_PCHK and S_PBYTE states (one store read port), pausing after a frame
// whose CRC1 and CRC2 pass; a false sync costs a replay of the bytes after it.
// A read transaction returns one big-endian word of the 3072-word burst: the
// header words are built without a store read, and frame words take two store
// reads. Requests queue two deep in front of the parser, and a finished result
// waits in the output register while the next request is taken. The store is
// not cleared: burst words that map to ring entries never written are undefined.
module ac3_frame_sync_iec_burst_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [11:0] word_index_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        frame_ready_o,
  output      logic [15:0] read_word_o,
  output      logic [1:0]  rate_code_o,
  output      logic [10:0] frame_words_o,
  output      logic [2:0]  stream_mode_o,
  output      logic [15:0] skipped_bytes_o
);
  import ac3fs_pkg::*;

  logic          q_valid, q_pop;
  req_t          q_req;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // Request queue
  ac3fs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .data_byte_i,
    .word_index_i, .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop)
  );

  // Parser and burst reader
  ac3fs_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop),
    .mem_we_o(mem_we), .mem_waddr_o(mem_waddr), .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr), .mem_rdata_i(mem_rdata),
    .out_valid_o, .out_stall_i, .frame_ready_o, .read_word_o, .rate_code_o,
    .frame_words_o, .stream_mode_o, .skipped_bytes_o
  );

  // Frame byte ring
  ac3fs_ram #(.Width(8), .Depth(STORE_BYTES)) u_store (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  // A frame result comes from a push, which returns no burst word
  a_ready_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ready_o |-> read_word_o == 16'd0)
    else $error("frame result carries a burst word");

  // An accepted frame has a length from the size table
  a_ready_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ready_o |-> frame_words_o >= 11'd64 && frame_words_o <= 11'd1920)
    else $error("accepted frame length out of range");

  // Reserved sample rate is never held
  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rate_code_o != 2'd3)
    else $error("reserved rate code");
endmodule
`default_nettype wire
